// ===== hdl/tsa_pkg.sv =====
package tsa_pkg;

	localparam int DIM_W       = 13;
	localparam int POS_W       = 12;
	localparam int ADDR_W      = 24;
	localparam int QUO_W       = 26;
	localparam int DVS_W       = 14;
	localparam int RECIP_SHIFT = 25;
	localparam int IDX_W       = 2;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_TILES  = 2'd2;

	typedef struct packed {
		logic [DIM_W-1:0] dim;
		logic [DIM_W-1:0] dim_last;
		logic [DIM_W-1:0] span;
		logic [DIM_W-1:0] base;
		logic [DVS_W-1:0] base_p1;
		logic [QUO_W-1:0] m_big;
		logic [QUO_W-1:0] m_small;
		logic [DIM_W-1:0] n;
	} axis_cfg_t;

endpackage

// ===== hdl/tsa_if.sv =====
interface tsa_req_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_row;
	logic [11:0] out_col;

	modport source (output valid, output out_row, output out_col, input ready);
	modport sink (input valid, input out_row, input out_col, output ready);
endinterface

interface tsa_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] src_row;
	logic [11:0] src_col;
	logic [23:0] src_address;

	modport source (output valid, output src_row, output src_col, output src_address,
		input ready);
	modport sink (input valid, input src_row, input src_col, input src_address,
		output ready);
endinterface

// ===== hdl/tsa_div.sv =====
module tsa_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tsa_pkg::QUO_W-1:0]      dividend,
	input  logic [tsa_pkg::DVS_W-1:0]      divisor,
	output logic                           done,
	output logic [tsa_pkg::QUO_W-1:0]      quotient,
	output logic [tsa_pkg::DVS_W-1:0]      remainder
);

	logic [4:0]                      cnt_q;
	logic                            done_q;
	logic [tsa_pkg::DVS_W-1:0]       rem_q;
	logic [tsa_pkg::QUO_W-1:0]       quo_q;
	logic [tsa_pkg::DVS_W-1:0]       div_q;
	logic [tsa_pkg::DVS_W+1:0]       trial;
	logic                            neg;

	assign trial = {1'b0, rem_q, quo_q[tsa_pkg::QUO_W-1]} - {2'b00, div_q};
	assign neg   = trial[tsa_pkg::DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 5'(tsa_pkg::QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= neg ? {rem_q[tsa_pkg::DVS_W-2:0], quo_q[tsa_pkg::QUO_W-1]}
				: trial[tsa_pkg::DVS_W-1:0];
			quo_q <= {quo_q[tsa_pkg::QUO_W-2:0], ~neg};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/tsa_cfg.sv =====
module tsa_cfg #(
	parameter int MAX_DIM = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsa_pkg::IDX_W-1:0]      cfg_index,
	input  logic [tsa_pkg::DIM_W-1:0]      cfg_data,
	output tsa_pkg::axis_cfg_t             row_cfg,
	output tsa_pkg::axis_cfg_t             col_cfg,
	output logic                           ready
);

	localparam logic [tsa_pkg::DIM_W-1:0] MaxDimW =
		(MAX_DIM > 8191) ? 13'h1FFF : 13'(MAX_DIM);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BASE  = 3'd1;
	localparam logic [2:0] ST_SPAN  = 3'd2;
	localparam logic [2:0] ST_BIG   = 3'd3;
	localparam logic [2:0] ST_SMALL = 3'd4;

	localparam logic [tsa_pkg::QUO_W-1:0] RecipOne = 26'(1) << tsa_pkg::RECIP_SHIFT;

	function automatic logic [tsa_pkg::DIM_W-1:0] clamp_reg(
		input logic [tsa_pkg::DIM_W-1:0] v);
		logic [tsa_pkg::DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = 13'd1;
		end else if (v > MaxDimW) begin
			r = MaxDimW;
		end
		return r;
	endfunction

	logic [2:0]                    state_q;
	logic                          dirty_q;
	logic                          axis_q;
	logic                          start_q;
	logic [tsa_pkg::DIM_W-1:0]     width_q;
	logic [tsa_pkg::DIM_W-1:0]     height_q;
	logic [tsa_pkg::DIM_W-1:0]     tiles_q;

	logic [tsa_pkg::DIM_W-1:0]     dim_q;
	logic [tsa_pkg::DIM_W-1:0]     n_q;
	logic [tsa_pkg::DIM_W-1:0]     base_q;
	logic [tsa_pkg::DIM_W-1:0]     extra_q;
	logic [tsa_pkg::DIM_W-1:0]     span_q;
	logic [tsa_pkg::QUO_W-1:0]     m_big_q;
	logic [tsa_pkg::QUO_W-1:0]     dividend_q;
	logic [tsa_pkg::DVS_W-1:0]     divisor_q;
	tsa_pkg::axis_cfg_t            row_cfg_q;
	tsa_pkg::axis_cfg_t            col_cfg_q;

	logic                          div_done;
	logic [tsa_pkg::QUO_W-1:0]     quotient;
	logic [tsa_pkg::DVS_W-1:0]     remainder;
	logic [tsa_pkg::DVS_W-1:0]     base_p1;
	logic [27:0]                   span_full;
	tsa_pkg::axis_cfg_t            cur;

	tsa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (dividend_q),
		.divisor   (divisor_q),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	assign base_p1   = {1'b0, base_q} + 14'd1;
	assign span_full = 28'(extra_q) * 28'(base_p1);

	always_comb begin
		cur.dim      = dim_q;
		cur.dim_last = dim_q - 13'd1;
		cur.span     = span_q;
		cur.base     = base_q;
		cur.base_p1  = base_p1;
		cur.m_big    = m_big_q;
		cur.m_small  = quotient;
		cur.n        = n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dirty_q  <= 1'b1;
			axis_q   <= 1'b0;
			start_q  <= 1'b0;
			width_q  <= 13'd1;
			height_q <= 13'd1;
			tiles_q  <= 13'd1;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (dirty_q) begin
						dirty_q <= 1'b0;
						axis_q  <= 1'b0;
						start_q <= 1'b1;
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					if (div_done) begin
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					start_q <= 1'b1;
					state_q <= ST_BIG;
				end
				ST_BIG: begin
					if (div_done) begin
						start_q <= 1'b1;
						state_q <= ST_SMALL;
					end
				end
				ST_SMALL: begin
					if (div_done) begin
						if (!axis_q) begin
							axis_q  <= 1'b1;
							start_q <= 1'b1;
							state_q <= ST_BASE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					tsa_pkg::REG_WIDTH:  width_q  <= cfg_data;
					tsa_pkg::REG_HEIGHT: height_q <= cfg_data;
					tsa_pkg::REG_TILES:  tiles_q  <= cfg_data;
					default: ;
				endcase
				dirty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (dirty_q) begin
					dim_q      <= clamp_reg(height_q);
					n_q        <= clamp_reg(tiles_q);
					dividend_q <= 26'(clamp_reg(height_q));
					divisor_q  <= 14'(clamp_reg(tiles_q));
				end
			end
			ST_BASE: begin
				if (div_done) begin
					base_q  <= quotient[tsa_pkg::DIM_W-1:0];
					extra_q <= remainder[tsa_pkg::DIM_W-1:0];
				end
			end
			ST_SPAN: begin
				span_q     <= span_full[tsa_pkg::DIM_W-1:0];
				dividend_q <= RecipOne;
				divisor_q  <= base_p1;
			end
			ST_BIG: begin
				if (div_done) begin
					m_big_q   <= quotient;
					divisor_q <= (base_q == '0) ? 14'd1 : {1'b0, base_q};
				end
			end
			ST_SMALL: begin
				if (div_done) begin
					if (!axis_q) begin
						row_cfg_q  <= cur;
						dim_q      <= clamp_reg(width_q);
						dividend_q <= 26'(clamp_reg(width_q));
						divisor_q  <= 14'(n_q);
					end else begin
						col_cfg_q <= cur;
					end
				end
			end
			default: ;
		endcase
	end

	assign row_cfg = row_cfg_q;
	assign col_cfg = col_cfg_q;
	assign ready   = (state_q == ST_IDLE) && !dirty_q;

endmodule

// ===== hdl/tsa_axis.sv =====
module tsa_axis (
	input  logic                           clk,
	input  tsa_pkg::axis_cfg_t             cfg,
	input  logic [4:0]                     adv,
	input  logic [tsa_pkg::POS_W-1:0]      pos,
	output logic [tsa_pkg::DIM_W-1:0]      src
);

	logic [tsa_pkg::DIM_W-1:0]     pos_w;
	logic [tsa_pkg::DIM_W-1:0]     pos_c;
	logic [tsa_pkg::DIM_W-1:0]     pos_off;
	logic                          big;

	logic [tsa_pkg::POS_W-1:0]     x_s1, x_s2;
	logic [tsa_pkg::DVS_W-1:0]     d_s1, d_s2, d_s3;
	logic [tsa_pkg::QUO_W-1:0]     m_s1;
	logic [tsa_pkg::POS_W-1:0]     q_s2;
	logic [tsa_pkg::POS_W-1:0]     r_s3;
	logic [tsa_pkg::POS_W-1:0]     local_s4;
	logic [tsa_pkg::DIM_W-1:0]     src_s5;

	logic [37:0]                   prod;
	logic [25:0]                   qd;
	logic [24:0]                   lm;

	// clamp to the last pixel, then pick the wide or narrow tile region
	assign pos_w   = {1'b0, pos};
	assign pos_c   = (pos_w > cfg.dim_last) ? cfg.dim_last : pos_w;
	assign big     = pos_c < cfg.span;
	assign pos_off = pos_c - cfg.span;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			x_s1 <= big ? pos_c[tsa_pkg::POS_W-1:0] : pos_off[tsa_pkg::POS_W-1:0];
			d_s1 <= big ? cfg.base_p1 : {1'b0, cfg.base};
			m_s1 <= big ? cfg.m_big : cfg.m_small;
		end
	end

	// quotient estimate by reciprocal, low by at most one
	assign prod = 38'(x_s1) * 38'(m_s1);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			q_s2 <= prod[tsa_pkg::RECIP_SHIFT +: tsa_pkg::POS_W];
			x_s2 <= x_s1;
			d_s2 <= d_s1;
		end
	end

	assign qd = 26'(q_s2) * 26'(d_s2);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			r_s3 <= x_s2 - qd[tsa_pkg::POS_W-1:0];
			d_s3 <= d_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			local_s4 <= ({2'b00, r_s3} >= d_s3) ? r_s3 - d_s3[tsa_pkg::POS_W-1:0] : r_s3;
		end
	end

	assign lm = 25'(local_s4) * 25'(cfg.n);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			src_s5 <= lm[tsa_pkg::DIM_W-1:0];
		end
	end

	assign src = src_s5;

endmodule

// ===== hdl/image_tile_source_address_top.sv =====
// Tile source address generator: for each output pixel (row, column) it returns the
// source row, source column and linear source address of an N-by-N tiling of the image
// subsampled by N. Sustained rate is one item per clock unless result.ready is low or
// the configuration is busy. An item loads the first of six pipeline stages (clamp and
// select, reciprocal multiply, back-multiply, correction, scale by N, address
// multiply-add) at the edge that takes it. After reset and after every register write
// it computes per-axis tile sizes and reciprocals on one shared bit-serial divider
// (six divisions), holding ready low meanwhile; register writes are taken at any time.
module image_tile_source_address_top #(
	parameter int MAX_DIM = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsa_pkg::IDX_W-1:0]      cfg_index,
	input  logic [tsa_pkg::DIM_W-1:0]      cfg_data,
	tsa_req_if.sink                        request,
	tsa_res_if.source                      result
);

	tsa_pkg::axis_cfg_t            row_cfg;
	tsa_pkg::axis_cfg_t            col_cfg;
	logic                          cfg_ready;

	logic                          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [5:0]                    adv;
	logic [tsa_pkg::DIM_W-1:0]     row_src;
	logic [tsa_pkg::DIM_W-1:0]     col_src;
	logic [25:0]                   addr_full;
	logic [tsa_pkg::POS_W-1:0]     row_s6, col_s6;
	logic [tsa_pkg::ADDR_W-1:0]    addr_s6;

	tsa_cfg #(
		.MAX_DIM (MAX_DIM)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row_cfg   (row_cfg),
		.col_cfg   (col_cfg),
		.ready     (cfg_ready)
	);

	// a stage moves when it is empty or the next one moves
	assign adv[5] = !v_s6 || result.ready;
	assign adv[4] = !v_s5 || adv[5];
	assign adv[3] = !v_s4 || adv[4];
	assign adv[2] = !v_s3 || adv[3];
	assign adv[1] = !v_s2 || adv[2];
	assign adv[0] = !v_s1 || adv[1];

	assign request.ready = adv[0] && cfg_ready;

	tsa_axis u_row (
		.clk (clk),
		.cfg (row_cfg),
		.adv (adv[4:0]),
		.pos (request.out_row),
		.src (row_src)
	);

	tsa_axis u_col (
		.clk (clk),
		.cfg (col_cfg),
		.adv (adv[4:0]),
		.pos (request.out_col),
		.src (col_src)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv[0]) v_s1 <= request.valid && cfg_ready;
			if (adv[1]) v_s2 <= v_s1;
			if (adv[2]) v_s3 <= v_s2;
			if (adv[3]) v_s4 <= v_s3;
			if (adv[4]) v_s5 <= v_s4;
			if (adv[5]) v_s6 <= v_s5;
		end
	end

	assign addr_full = 26'(row_src) * 26'(col_cfg.dim) + 26'(col_src);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			row_s6  <= row_src[tsa_pkg::POS_W-1:0];
			col_s6  <= col_src[tsa_pkg::POS_W-1:0];
			addr_s6 <= addr_full[tsa_pkg::ADDR_W-1:0];
		end
	end

	assign result.valid       = v_s6;
	assign result.src_row     = row_s6;
	assign result.src_col     = col_s6;
	assign result.src_address = addr_s6;

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready |=> v_s1)
		else $error("accepted item did not enter the first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !adv[4] |=> v_s5)
		else $error("stalled item lost from stage five");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && result.ready |=> !v_s6 || $past(v_s5))
		else $error("result appeared without an item behind it");
`endif

endmodule

// ===== test/tile_addr_checker.sv =====
`timescale 1ns / 1ps

module tile_addr_checker #(
	parameter int MAX_DIM = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tsa_pkg::IDX_W-1:0] cfg_index,
	input  logic [tsa_pkg::DIM_W-1:0] cfg_data,
	tsa_req_if                        request,
	tsa_res_if                        result,
	output int                        pending,
	output int                        fail_count
);
	import tsa_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic [ADDR_W-1:0] addr;
	} src_loc_t;

	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [DIM_W-1:0] tiles_reg;
	src_loc_t         expected_q[$];

	function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return 32'(v);
	endfunction

	// leading dim % n tiles are one pixel longer than the rest
	function automatic int unsigned tile_coord(int unsigned pos, int unsigned dim,
		int unsigned n);
		int unsigned base;
		int unsigned big_span;
		int unsigned p;
		int unsigned offs;
		base     = dim / n;
		big_span = (dim % n) * (base + 1);
		p        = (pos >= dim) ? dim - 1 : pos;
		if (p < big_span)
			offs = p % (base + 1);
		else
			offs = (p - big_span) % base;
		return offs * n;
	endfunction

	function automatic src_loc_t locate_source(logic [POS_W-1:0] row, logic [POS_W-1:0] col);
		int unsigned w;
		int unsigned r;
		int unsigned c;
		int unsigned a;
		src_loc_t    loc;
		w        = eff_dim(width_reg);
		r        = tile_coord(32'(row), eff_dim(height_reg), eff_dim(tiles_reg));
		c        = tile_coord(32'(col), w, eff_dim(tiles_reg));
		a        = r * w + c;
		loc.row  = r[POS_W-1:0];
		loc.col  = c[POS_W-1:0];
		loc.addr = a[ADDR_W-1:0];
		return loc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		src_loc_t got;
		src_loc_t want;
		bit       bad;
		if (!arst_n) begin
			width_reg  <= 13'd1;
			height_reg <= 13'd1;
			tiles_reg  <= 13'd1;
			pending    <= 0;
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH: begin
						width_reg <= cfg_data;
					end
					REG_HEIGHT: begin
						height_reg <= cfg_data;
					end
					REG_TILES: begin
						tiles_reg <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (result.valid && result.ready) begin
				got.row  = result.src_row;
				got.col  = result.src_col;
				got.addr = result.src_address;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected item row %0d col %0d addr %0d", $time,
						got.row, got.col, got.addr);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					bad  = 1'b0;
					if (got.row !== want.row) begin
						$display("%0t: src_row expected %0d actual %0d", $time, want.row,
							got.row);
						bad = 1'b1;
					end
					if (got.col !== want.col) begin
						$display("%0t: src_col expected %0d actual %0d", $time, want.col,
							got.col);
						bad = 1'b1;
					end
					if (got.addr !== want.addr) begin
						$display("%0t: src_address expected %0d actual %0d", $time,
							want.addr, got.addr);
						bad = 1'b1;
					end
					if (bad)
						fail_count <= fail_count + 1;
				end
			end
			if (request.valid && request.ready)
				expected_q.push_back(locate_source(request.out_row, request.out_col));
			pending <= expected_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import tsa_pkg::*;

	localparam int MAX_DIM    = 4096;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES     = 16;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;
	int               pending;
	int               fail_count;
	int               idle_cycles = 0;
	int unsigned      w_eff;
	int unsigned      h_eff;
	bit               send_burst;
	bit               recv_burst;

	tsa_req_if req_ch();
	tsa_res_if res_ch();

	image_tile_source_address_top #(
		.MAX_DIM(MAX_DIM)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.request  (req_ch),
		.result   (res_ch)
	);

	tile_addr_checker #(
		.MAX_DIM(MAX_DIM)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (req_ch),
		.result    (res_ch),
		.pending   (pending),
		.fail_count(fail_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** image_tile_source_address_top: FAILED **");
			$finish;
		end
	end

	function automatic int unsigned usable(logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return 32'(v);
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim(bit tiles);
		int unsigned sel;
		sel = $urandom_range(0, 11);
		case (sel)
			0: return '0;
			1: return 13'($urandom_range(MAX_DIM + 1, 8191));
			2: return 13'(MAX_DIM);
			3, 4: return 13'($urandom_range(1, MAX_DIM));
			default: return tiles ? 13'($urandom_range(1, 12)) : 13'($urandom_range(1, 40));
		endcase
	endfunction

	task automatic send_item(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
		int unsigned gap;
		gap = send_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.out_row <= row;
		req_ch.out_col <= col;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
		input logic [DIM_W-1:0] n);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_index <= REG_TILES;
		cfg_data  <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		w_eff = usable(w);
		h_eff = usable(h);
	endtask

	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int unsigned stall;
			stall = recv_burst ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	initial begin
		int          count;
		logic [11:0] row;
		logic [11:0] col;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= REG_WIDTH;
		cfg_data       <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.out_row <= '0;
		req_ch.out_col <= '0;
		send_burst     = 1'b0;
		recv_burst     = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, one position in range and one far out of range
		send_item(12'd0, 12'd0);
		send_item(12'd4095, 12'd4095);

		// zero register and oversized registers
		set_config(13'd0, 13'd8191, 13'd4097);
		send_item(12'd4095, 12'd0);
		send_item(12'd0, 12'd4095);
		send_item(12'd2048, 12'd7);

		set_config(13'd4096, 13'd4096, 13'd1);
		send_item(12'd4095, 12'd4095);
		send_item(12'd0, 12'd4095);
		send_item(12'd4095, 12'd0);

		// long and short tiles, boundaries on both axes
		set_config(13'd10, 13'd7, 13'd3);
		send_item(12'd2, 12'd3);
		send_item(12'd3, 12'd4);
		send_item(12'd6, 12'd9);

		// more tiles than pixels: empty tiles
		set_config(13'd5, 13'd3, 13'd8);
		send_item(12'd0, 12'd0);
		send_item(12'd2, 12'd4);
		send_item(12'd1, 12'd3);

		set_config(13'd4095, 13'd4095, 13'd4095);
		send_item(12'd4094, 12'd4094);
		send_item(12'd4095, 12'd4095);

		set_config(13'd4096, 13'd1, 13'd64);
		send_item(12'd0, 12'd4095);
		send_item(12'd0, 12'd100);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_config(pick_dim(1'b0), pick_dim(1'b0), pick_dim(1'b1));
			send_burst = ($urandom_range(0, 3) == 0);
			recv_burst = ($urandom_range(0, 3) == 0);
			count      = $urandom_range(30, 76);
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 4) == 0)
					row = 12'($urandom_range(0, 4095));
				else
					row = 12'($urandom_range(0, h_eff - 1));
				if ($urandom_range(0, 4) == 0)
					col = 12'($urandom_range(0, 4095));
				else
					col = 12'($urandom_range(0, w_eff - 1));
				send_item(row, col);
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("** image_tile_source_address_top: PASSED **");
		else
			$display("** image_tile_source_address_top: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tsa_pkg.sv
hdl/tsa_if.sv
hdl/tsa_div.sv
hdl/tsa_cfg.sv
hdl/tsa_axis.sv
hdl/image_tile_source_address_top.sv
test/tile_addr_checker.sv
test/tb_top.sv
